// ----- src/md5sh_pkg.sv -----
// Shared types, constants and round functions of the MD5 stream hasher.
package md5sh_pkg;

  typedef logic [15:0][31:0] block_t;

  typedef struct packed {
    logic valid;
    logic last_blk;
  } bq_push_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last_blk;
  } bq_stat_t;

  typedef struct packed {
    logic       pop;
    logic [3:0] idx;
  } bq_rd_t;

  localparam int QDEPTH = 2;
  localparam logic [5:0] PAD_LIMIT = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] INIT_CHAIN [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r;
    r = rnd[3:0];
    case (rnd[5:4])
      2'd0: msg_index = r;
      2'd1: msg_index = 4'(4'd5 * r + 4'd1);
      2'd2: msg_index = 4'(4'd3 * r + 4'd5);
      default: msg_index = 4'(4'd7 * r);
    endcase
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    rot_amount = ROT_TAB[{rnd[5:4], rnd[1:0]}];
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] w;
    w = {v, v} << s;
    rotl32 = w[63:32];
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    case (grp)
      2'd0: round_f = d ^ (b & (c ^ d));
      2'd1: round_f = c ^ (d & (b ^ c));
      2'd2: round_f = b ^ c ^ d;
      default: round_f = c ^ (b | ~d);
    endcase
  endfunction

endpackage

// ----- src/md5sh_in_if.sv -----
// Input channel: one message byte beat with has_byte and last flags.
interface md5sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last, input ready);
  modport sink (input valid, input data_byte, input has_byte, input last, output ready);
endinterface

// ----- src/md5sh_out_if.sv -----
// Output channel: one digest word beat with its index and last flag.
interface md5sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// ----- src/md5sh_front.sv -----
// Front end: packs bytes into a block, counts them and builds padded blocks.
module md5sh_front import md5sh_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  md5sh_in_if.sink     in_ch,
  output bq_push_t     push,
  output block_t       push_blk,
  input  bq_stat_t     qstat
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_FULL = 2'd1;
  localparam logic [1:0] F_PAD  = 2'd2;
  localparam logic [1:0] F_LEN  = 2'd3;

  logic [1:0]       state;
  logic [60:0]      byte_count;
  logic             fin_pend;
  logic [63:0][7:0] blk_bytes;
  logic [63:0][7:0] pad_bytes;
  logic [5:0]       pos;
  logic [63:0]      bit_len;
  logic             accept;
  logic             short_pad;
  block_t           pad_blk;
  block_t           len_blk;

  assign pos       = byte_count[5:0];
  assign bit_len   = {byte_count, 3'b000};
  assign short_pad = pos < PAD_LIMIT;
  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == F_IDLE);

  always_comb begin
    for (int p = 0; p < 64; p++) begin
      if (6'(p) < pos) begin
        pad_bytes[p] = blk_bytes[p];
      end else if (6'(p) == pos) begin
        pad_bytes[p] = PAD_BYTE;
      end else begin
        pad_bytes[p] = 8'h00;
      end
    end
    pad_blk = block_t'(pad_bytes);
    if (short_pad) begin
      pad_blk[14] = bit_len[31:0];
      pad_blk[15] = bit_len[63:32];
    end
    len_blk = '0;
    len_blk[14] = bit_len[31:0];
    len_blk[15] = bit_len[63:32];
  end

  always_comb begin
    push.valid    = (state != F_IDLE) && !qstat.full;
    push.last_blk = (state == F_LEN) || ((state == F_PAD) && short_pad);
    case (state)
      F_FULL:  push_blk = block_t'(blk_bytes);
      F_PAD:   push_blk = pad_blk;
      default: push_blk = len_blk;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      byte_count <= '0;
      fin_pend   <= 1'b0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            if (in_ch.has_byte) begin
              byte_count <= byte_count + 61'd1;
            end
            if (in_ch.has_byte && pos == LAST_POS) begin
              state    <= F_FULL;
              fin_pend <= in_ch.last;
            end else if (in_ch.last) begin
              state <= F_PAD;
            end
          end
        end
        F_FULL: begin
          if (push.valid) begin
            state <= fin_pend ? F_PAD : F_IDLE;
          end
        end
        F_PAD: begin
          if (push.valid) begin
            if (short_pad) begin
              byte_count <= '0;
              state      <= F_IDLE;
            end else begin
              state <= F_LEN;
            end
          end
        end
        F_LEN: begin
          if (push.valid) begin
            byte_count <= '0;
            state      <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.has_byte) begin
      blk_bytes[pos] <= in_ch.data_byte;
    end
  end

endmodule

// ----- src/md5sh_blkq.sv -----
// Block queue between the front end and the compression engine.
module md5sh_blkq import md5sh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  bq_push_t push,
  input  block_t   push_blk,
  input  bq_rd_t   rd,
  output logic [31:0] rd_word,
  output bq_stat_t qstat
);

  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  block_t            q_blk  [QDEPTH];
  logic [QDEPTH-1:0] q_last;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;
  logic              do_push;
  logic              do_pop;

  assign qstat.full     = (cnt == QCNT_W'(QDEPTH));
  assign qstat.empty    = (cnt == '0);
  assign qstat.last_blk = q_last[rd_ptr];
  assign rd_word        = q_blk[rd_ptr][rd.idx];
  assign do_push        = push.valid && !qstat.full;
  assign do_pop         = rd.pop && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_blk[wr_ptr]  <= push_blk;
      q_last[wr_ptr] <= push.last_blk;
    end
  end

endmodule

// ----- src/md5sh_back.sv -----
// Back end: 64-round compression, chaining update and digest word output.
module md5sh_back import md5sh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  bq_stat_t    qstat,
  output bq_rd_t      rd,
  input  logic [31:0] rd_word,
  md5sh_out_if.source out_ch
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_FOLD = 2'd2;
  localparam logic [1:0] B_OUT  = 2'd3;

  logic [1:0]  state;
  logic [5:0]  rnd;
  logic [1:0]  widx;
  logic [31:0] chain [4];
  logic [31:0] ra, rb, rc, rd_w;
  logic [31:0] t_sum;
  logic [31:0] b_next;
  logic        out_valid;
  logic [31:0] out_word;
  logic [1:0]  out_idx;
  logic        out_last;
  logic        out_load;

  assign rd.idx = msg_index(rnd);
  assign rd.pop = (state == B_FOLD);

  assign t_sum  = ra + round_f(rnd[5:4], rb, rc, rd_w) + rd_word + ROUND_K[rnd];
  assign b_next = rb + rotl32(t_sum, rot_amount(rnd));

  assign out_load = (state == B_OUT) && (!out_valid || out_ch.ready);

  assign out_ch.valid       = out_valid;
  assign out_ch.digest_word = out_word;
  assign out_ch.word_index  = out_idx;
  assign out_ch.last_word   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rnd       <= '0;
      widx      <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        chain[k] <= INIT_CHAIN[k];
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!qstat.empty) begin
            rnd   <= '0;
            state <= B_RUN;
          end
        end
        B_RUN: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= B_FOLD;
          end
        end
        B_FOLD: begin
          chain[0] <= chain[0] + ra;
          chain[1] <= chain[1] + rb;
          chain[2] <= chain[2] + rc;
          chain[3] <= chain[3] + rd_w;
          widx     <= '0;
          state    <= qstat.last_blk ? B_OUT : B_IDLE;
        end
        B_OUT: begin
          if (out_load) begin
            widx <= widx + 2'd1;
            if (widx == 2'd3) begin
              for (int k = 0; k < 4; k++) begin
                chain[k] <= INIT_CHAIN[k];
              end
              state <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE) begin
      ra   <= chain[0];
      rb   <= chain[1];
      rc   <= chain[2];
      rd_w <= chain[3];
    end else if (state == B_RUN) begin
      ra   <= rd_w;
      rd_w <= rc;
      rc   <= rb;
      rb   <= b_next;
    end
    if (out_load) begin
      out_word <= chain[widx];
      out_idx  <= widx;
      out_last <= (widx == 2'd3);
    end
  end

endmodule

// ----- src/md5_stream_hasher_core.sv -----
// MD5 stream hasher top level: byte input, digest word output.
//
// in_ch takes one beat per message byte (has_byte 1) and may carry last to
// close the message; a beat with has_byte 0 and last 1 closes an empty tail.
// The front end packs bytes into a 64-byte block and hands full and padded
// blocks to a two-entry block queue; it takes one beat per cycle while idle
// and holds in_ch while it hands on a full block or the padding blocks.
// The compression engine runs one round per cycle; each block takes a load
// step, 64 rounds and a chaining add, which sets the sustained rate. Beyond
// the hand-over, in_ch stalls only while both queue entries wait.
// After the closing beat, the digest appears on out_ch as four beats, A
// through D, word_index 0..3, last_word on D, once the last block is
// compressed, which is an extra block when the length needs one.
// A stalled out_ch holds the current word and the engine waits; the front
// end keeps taking bytes until the queue fills.
// rst (synchronous) restores the initial chaining words, clears the byte
// count and empties the queue; no beat is pending afterwards.
module md5_stream_hasher_core import md5sh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  md5sh_in_if.sink    in_ch,
  md5sh_out_if.source out_ch
);

  bq_push_t    push;
  block_t      push_blk;
  bq_stat_t    qstat;
  bq_rd_t      rd;
  logic [31:0] rd_word;

  md5sh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .push     (push),
    .push_blk (push_blk),
    .qstat    (qstat)
  );

  md5sh_blkq u_blkq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_blk (push_blk),
    .rd       (rd),
    .rd_word  (rd_word),
    .qstat    (qstat)
  );

  md5sh_back u_back (
    .clk     (clk),
    .rst     (rst),
    .qstat   (qstat),
    .rd      (rd),
    .rd_word (rd_word),
    .out_ch  (out_ch)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !qstat.full)
    else $error("block pushed into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    rd.pop |-> !qstat.empty)
    else $error("block popped from an empty queue");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.last_word == (out_ch.word_index == 2'd3)))
    else $error("last_word does not match word D");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !out_ch.last_word) ##1 out_ch.valid
      |-> out_ch.word_index == $past(out_ch.word_index) + 2'd1)
    else $error("digest words out of order");

endmodule
